### rtl/pll_rrc_pkg.sv
// shared types, codes and constants for the reference ratio checker
`timescale 1ns / 1ps
package pll_rrc_pkg;

	localparam int NUM_W = 36;
	localparam int DEN_W = 20;
	localparam int CNT_W = 6;

	localparam logic [7:0] MULT_LOW      = 8'd3;
	localparam logic [7:0] MULT_HIGH     = 8'd7;
	localparam logic [2:0] DOUBLE_FACTOR = 3'd2;

	localparam logic [1:0] ST_MATCH    = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;

	typedef struct packed {
		logic [31:0]      ref_freq_hz;
		logic [7:0]       doubler_on;
		logic [11:0]      pre_divider;
		logic [7:0]       multiplier;
		logic [7:0]       post_divider;
		logic [NUM_W-1:0] claimed_num;
		logic [DEN_W-1:0] claimed_den;
	} setting_word_t;

	typedef struct packed {
		logic [1:0]       check_status;
		logic [NUM_W-1:0] reduced_num;
		logic [DEN_W-1:0] reduced_den;
	} result_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_GCD_TEST,
		S_MOD,
		S_MOD_SWAP,
		S_DIV_NUM,
		S_NUM_SAVE,
		S_DIV_DEN,
		S_DEN_SAVE,
		S_FINISH
	} ctrl_state_t;

	// operand pair loaded into the shared divider
	typedef enum logic [1:0] {
		DIV_SRC_XY,
		DIV_SRC_NUM,
		DIV_SRC_DEN
	} div_src_t;

	typedef struct packed {
		logic     capture;
		logic     setup;
		logic     div_start;
		div_src_t div_src;
		logic     div_step;
		logic     gcd_swap;
		logic     num_save;
		logic     den_save;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic y_zero;
		logic div_last;
	} dp_sts_t;

endpackage

### rtl/pll_reference_ratio_check.sv
// top level of the reference ratio checker: controller plus datapath
// an invalid setting skips the euclid steps and the final divisions; a valid one runs
//   the euclid remainder steps, then divides numerator and denominator by the gcd
// one word at a time: a new setting is taken only in idle, after the result is loaded;
//   each euclid step and each final division runs through the single bit-serial divider
// reset: arst_n clears the controller to idle and the output valid flag
`timescale 1ns / 1ps
module pll_reference_ratio_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       setting_valid,
	output logic                       setting_stall,
	input  pll_rrc_pkg::setting_word_t setting,
	output logic                       result_valid,
	input  logic                       result_stall,
	output pll_rrc_pkg::result_word_t  result
);
	import pll_rrc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller
	pll_rrc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.setting_valid (setting_valid),
		.setting_stall (setting_stall),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.cmd           (cmd),
		.sts           (sts)
	);

	// datapath
	pll_rrc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.setting (setting),
		.result  (result),
		.cmd     (cmd),
		.sts     (sts)
	);

`ifndef NO_ASSERTIONS
	// an accepted word keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(setting_valid && !setting_stall) |=> setting_stall)
		else $error("block accepted a word without going busy");

	// invalid settings give zero fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.check_status == ST_INVALID)) |->
		((result.reduced_num == '0) && (result.reduced_den == '0)))
		else $error("invalid setting with nonzero reduced fraction");

	// a checked fraction always has a nonzero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.check_status != ST_INVALID)) |->
		(result.reduced_den != '0))
		else $error("reduced denominator is zero");

	// status code is one of the three defined ones
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.check_status == ST_MATCH) ||
		(result.check_status == ST_INVALID) || (result.check_status == ST_MISMATCH)))
		else $error("undefined status code");
`endif

endmodule

### rtl/pll_rrc_ctrl.sv
// controller state machine: sequences setup, euclid steps and the final divisions
`timescale 1ns / 1ps
module pll_rrc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                setting_valid,
	output logic                setting_stall,
	output logic                result_valid,
	input  logic                result_stall,
	output pll_rrc_pkg::dp_cmd_t cmd,
	input  pll_rrc_pkg::dp_sts_t sts
);
	import pll_rrc_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free     = !out_valid_q || !result_stall;
	assign setting_stall = (state_q != S_IDLE);
	assign result_valid  = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_src = DIV_SRC_XY;
		unique case (state_q)
			S_IDLE: begin
				if (setting_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_GCD_TEST;
			end
			S_GCD_TEST: begin
				if (sts.bad) begin
					state_d = S_FINISH;
				end else if (sts.y_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_src   = DIV_SRC_NUM;
					state_d       = S_DIV_NUM;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_src   = DIV_SRC_XY;
					state_d       = S_MOD;
				end
			end
			S_MOD: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_MOD_SWAP;
				end
			end
			S_MOD_SWAP: begin
				cmd.gcd_swap = 1'b1;
				state_d      = S_GCD_TEST;
			end
			S_DIV_NUM: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_NUM_SAVE;
				end
			end
			S_NUM_SAVE: begin
				cmd.num_save  = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_src   = DIV_SRC_DEN;
				state_d       = S_DIV_DEN;
			end
			S_DIV_DEN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DEN_SAVE;
				end
			end
			S_DEN_SAVE: begin
				cmd.den_save = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/pll_rrc_dp.sv
// datapath: setting capture, products, euclid registers, bit-serial divider, output word
`timescale 1ns / 1ps
module pll_rrc_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pll_rrc_pkg::setting_word_t setting,
	output pll_rrc_pkg::result_word_t  result,
	input  pll_rrc_pkg::dp_cmd_t       cmd,
	output pll_rrc_pkg::dp_sts_t       sts
);
	import pll_rrc_pkg::*;

	setting_word_t    cap_q;
	result_word_t     result_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] x_q;
	logic [DEN_W-1:0] y_q;
	logic [NUM_W-1:0] dvd_q;
	logic [DEN_W-1:0] dvs_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             bad_q;

	logic             mult_bad;
	logic             bad_c;
	logic [2:0]       factor;
	logic [NUM_W-1:0] prod_num;
	logic [DEN_W-1:0] prod_den;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic             match;

	// setting check
	always_comb begin
		mult_bad = (cap_q.multiplier != 8'd1) &&
			((cap_q.multiplier < MULT_LOW) || (cap_q.multiplier > MULT_HIGH));
		bad_c = (cap_q.pre_divider == 12'd0) || (cap_q.post_divider == 8'd0) ||
			(cap_q.doubler_on > 8'd1) || mult_bad ||
			((cap_q.doubler_on != 8'd0) && (cap_q.multiplier != 8'd1));
	end

	// products; a valid setting has either the doubler or the multiplier, never both
	assign factor   = (cap_q.doubler_on != 8'd0) ? DOUBLE_FACTOR : cap_q.multiplier[2:0];
	assign prod_num = NUM_W'(cap_q.ref_freq_hz) * NUM_W'(factor);
	assign prod_den = DEN_W'(cap_q.pre_divider) * DEN_W'(cap_q.post_divider);

	// restoring divider step: one quotient bit per cycle
	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	assign match = (num_q == cap_q.claimed_num) && (den_q == cap_q.claimed_den);

	assign sts.bad      = bad_q;
	assign sts.y_zero   = (y_q == '0);
	assign sts.div_last = (cnt_q == CNT_W'(NUM_W - 1));
	assign result       = result_q;

	// step counter and invalid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			bad_q <= 1'b0;
		end else begin
			if (cmd.setup) begin
				bad_q <= bad_c;
			end
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_q <= setting;
		end
		if (cmd.setup) begin
			num_q <= prod_num;
			den_q <= prod_den;
			x_q   <= prod_num;
			y_q   <= prod_den;
		end
		if (cmd.gcd_swap) begin
			x_q <= NUM_W'(y_q);
			y_q <= rem_q;
		end
		if (cmd.num_save) begin
			num_q <= dvd_q;
		end
		if (cmd.den_save) begin
			den_q <= dvd_q[DEN_W-1:0];
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			unique case (cmd.div_src)
				DIV_SRC_XY: begin
					dvd_q <= x_q;
					dvs_q <= y_q;
				end
				DIV_SRC_NUM: begin
					dvd_q <= num_q;
					dvs_q <= x_q[DEN_W-1:0];
				end
				DIV_SRC_DEN: begin
					dvd_q <= NUM_W'(den_q);
					dvs_q <= x_q[DEN_W-1:0];
				end
				default: begin
					dvd_q <= x_q;
					dvs_q <= y_q;
				end
			endcase
		end else if (cmd.div_step) begin
			if (fits) begin
				rem_q <= DEN_W'(trial - {1'b0, dvs_q});
				dvd_q <= {dvd_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
			end
		end
		// output word
		if (cmd.out_load) begin
			if (bad_q) begin
				result_q.check_status <= ST_INVALID;
				result_q.reduced_num  <= '0;
				result_q.reduced_den  <= '0;
			end else begin
				result_q.check_status <= match ? ST_MATCH : ST_MISMATCH;
				result_q.reduced_num  <= num_q;
				result_q.reduced_den  <= den_q;
			end
		end
	end

endmodule

### test/pll_reference_ratio_check_test.sv
// testbench for the reference ratio checker: random and directed settings against a predictor
`timescale 1ns / 1ps
module pll_reference_ratio_check_test;
	import pll_rrc_pkg::*;

	localparam int HOLD_CYCLES  = 3000;
	localparam int TAIL_CYCLES  = 1300;
	localparam int IDLE_LIMIT   = 20000;
	localparam int RANDOM_WORDS = 300;

	// expected results in acceptance order, with the ratio predictor
	class ratio_scoreboard;
		result_word_t pending_results[$];
		int unsigned failures = 0;

		function result_word_t predict_ratio(setting_word_t s);
			logic [63:0] num;
			logic [63:0] den;
			logic [63:0] x;
			logic [63:0] y;
			logic [63:0] r;
			logic mult_bad;
			logic bad;
			result_word_t res;
			mult_bad = (s.multiplier != 8'd1) &&
				((s.multiplier < MULT_LOW) || (s.multiplier > MULT_HIGH));
			bad = (s.pre_divider == 0) || (s.post_divider == 0) || (s.doubler_on > 8'd1) ||
				mult_bad || ((s.doubler_on != 0) && (s.multiplier != 8'd1));
			if (bad) begin
				res.check_status = ST_INVALID;
				res.reduced_num = '0;
				res.reduced_den = '0;
				return res;
			end
			num = 64'(s.ref_freq_hz) * 64'(s.multiplier) *
				((s.doubler_on != 0) ? 64'(DOUBLE_FACTOR) : 64'd1);
			den = 64'(s.pre_divider) * 64'(s.post_divider);
			// euclid on the full fraction, den is never zero here
			x = num;
			y = den;
			while (y != 0) begin
				r = x % y;
				x = y;
				y = r;
			end
			num = num / x;
			den = den / x;
			res.reduced_num = num[NUM_W-1:0];
			res.reduced_den = den[DEN_W-1:0];
			res.check_status = ((res.reduced_num == s.claimed_num) &&
				(res.reduced_den == s.claimed_den)) ? ST_MATCH : ST_MISMATCH;
			return res;
		endfunction

		function void note_setting(setting_word_t s);
			pending_results.push_back(predict_ratio(s));
		endfunction

		function void check_result(result_word_t got);
			result_word_t want;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result word: expected none, actual %h", $time, got);
				failures++;
				return;
			end
			want = pending_results.pop_front();
			if (got.check_status !== want.check_status) begin
				$display("%0t check_status mismatch: expected %0d, actual %0d",
					$time, want.check_status, got.check_status);
				failures++;
			end
			if (got.reduced_num !== want.reduced_num) begin
				$display("%0t reduced_num mismatch: expected %0d, actual %0d",
					$time, want.reduced_num, got.reduced_num);
				failures++;
			end
			if (got.reduced_den !== want.reduced_den) begin
				$display("%0t reduced_den mismatch: expected %0d, actual %0d",
					$time, want.reduced_den, got.reduced_den);
				failures++;
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          setting_valid;
	logic          setting_stall;
	setting_word_t setting;
	logic          result_valid;
	logic          result_stall;
	result_word_t  result;

	ratio_scoreboard board;
	logic calm = 1'b0;
	logic hold_request = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   idle_cycles = 0;

	pll_reference_ratio_check u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.setting_valid (setting_valid),
		.setting_stall (setting_stall),
		.setting       (setting),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

	// clock
	always #4 clk = ~clk;

	function automatic setting_word_t make_setting(logic [31:0] ref_hz, logic [7:0] dbl,
		logic [11:0] pre, logic [7:0] mult, logic [7:0] post,
		logic [NUM_W-1:0] cnum, logic [DEN_W-1:0] cden);
		setting_word_t s;
		s.ref_freq_hz = ref_hz;
		s.doubler_on = dbl;
		s.pre_divider = pre;
		s.multiplier = mult;
		s.post_divider = post;
		s.claimed_num = cnum;
		s.claimed_den = cden;
		return s;
	endfunction

	// overwrite the claim with the correctly reduced fraction
	function automatic setting_word_t with_true_claim(setting_word_t s);
		result_word_t r;
		r = board.predict_ratio(s);
		s.claimed_num = r.reduced_num;
		s.claimed_den = r.reduced_den;
		return s;
	endfunction

	// mostly well-formed settings, some noise across all bits
	function automatic setting_word_t random_setting();
		logic [7:0] mult_pick[6] = '{8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};
		setting_word_t s;
		s.claimed_num = NUM_W'({$urandom, $urandom});
		s.claimed_den = DEN_W'($urandom);
		if ($urandom_range(99) < 20) begin
			s.ref_freq_hz = $urandom;
			s.doubler_on = 8'($urandom);
			s.pre_divider = 12'($urandom);
			s.multiplier = 8'($urandom);
			s.post_divider = 8'($urandom);
			return s;
		end
		case ($urandom_range(3))
			0: s.ref_freq_hz = $urandom;
			1: s.ref_freq_hz = $urandom_range(1000);
			2: s.ref_freq_hz = 32'd1_000_000 * $urandom_range(1, 4000);
			default: s.ref_freq_hz = 32'hFFFF_FFFF - $urandom_range(3);
		endcase
		if ($urandom_range(1)) begin
			s.doubler_on = 8'd1;
			s.multiplier = 8'd1;
		end else begin
			s.doubler_on = 8'd0;
			s.multiplier = mult_pick[$urandom_range(5)];
		end
		s.pre_divider = 12'($urandom_range(1) ? $urandom_range(1, 16) :
			$urandom_range(1, 4095));
		s.post_divider = 8'($urandom_range(1, 255));
		// true claim, claim off by one bit, or random claim
		case ($urandom_range(3))
			0, 1: s = with_true_claim(s);
			2: begin
				s = with_true_claim(s);
				if ($urandom_range(1))
					s.claimed_num ^= (36'd1 << $urandom_range(NUM_W - 1));
				else
					s.claimed_den ^= (20'd1 << $urandom_range(DEN_W - 1));
			end
			default: ;
		endcase
		return s;
	endfunction

	// offer one word, with random idle cycles ahead of it
	task automatic send_setting(setting_word_t s);
		while (!calm && hold_left == 0 && $urandom_range(99) < 27) begin
			setting_valid <= 1'b0;
			@(negedge clk);
		end
		setting_valid <= 1'b1;
		setting <= s;
		@(posedge clk);
		while (setting_stall)
			@(posedge clk);
		board.note_setting(s);
		@(negedge clk);
	endtask

	// receiver stall: random, calm stretch, and one long hold-off
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (calm)
				result_stall <= 1'b0;
			else
				result_stall <= ($urandom_range(99) < 27);
		end
	end

	// result word checking
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(result);
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((setting_valid && !setting_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// main sequence
	initial begin
		board = new();
		arst_n = 1'b0;
		setting_valid = 1'b0;
		setting = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: valid extremes and claims
		send_setting(with_true_claim(make_setting(32'd10_000_000, 8'd0, 12'd1, 8'd1, 8'd1,
			'0, '0)));
		send_setting(with_true_claim(make_setting(32'd0, 8'd0, 12'd3, 8'd4, 8'd9, '0, '0)));
		send_setting(with_true_claim(make_setting(32'd0, 8'd1, 12'd4095, 8'd1, 8'd255,
			'0, '0)));
		send_setting(with_true_claim(make_setting(32'hFFFF_FFFF, 8'd0, 12'd1, 8'd7, 8'd1,
			'0, '0)));
		send_setting(with_true_claim(make_setting(32'hFFFF_FFFF, 8'd1, 12'd4095, 8'd1, 8'd255,
			'0, '0)));
		send_setting(with_true_claim(make_setting(32'd1, 8'd0, 12'd4095, 8'd1, 8'd255,
			'0, '0)));
		send_setting(with_true_claim(make_setting(32'd122_880_000, 8'd0, 12'd5, 8'd6, 8'd8,
			'0, '0)));
		send_setting(with_true_claim(make_setting(32'd100_000_000, 8'd0, 12'd7, 8'd3, 8'd3,
			'0, '0)));
		// claim left unreduced
		send_setting(make_setting(32'hFFFF_FFFF, 8'd0, 12'd4095, 8'd5, 8'd255,
			36'hFFFF_FFFF * 36'd5, 20'd4095 * 20'd255));
		// claim with zero denominator
		send_setting(make_setting(32'd100_000_000, 8'd0, 12'd7, 8'd3, 8'd3,
			36'd100_000_000, 20'd0));
		// all ones claim
		send_setting(make_setting(32'd38_400_000, 8'd0, 12'd2, 8'd1, 8'd1, '1, '1));
		// invalid settings
		send_setting(make_setting(32'd10_000_000, 8'd0, 12'd0, 8'd1, 8'd1, '1, '1));
		send_setting(make_setting(32'd10_000_000, 8'd0, 12'd1, 8'd1, 8'd0, '0, '0));
		send_setting(make_setting(32'd10_000_000, 8'd2, 12'd1, 8'd1, 8'd1, '0, 20'd1));
		send_setting(make_setting(32'hFFFF_FFFF, 8'd255, 12'd4095, 8'd1, 8'd255, '0, '0));
		send_setting(make_setting(32'd10_000_000, 8'd0, 12'd1, 8'd0, 8'd1, '0, '0));
		send_setting(make_setting(32'd10_000_000, 8'd0, 12'd1, 8'd2, 8'd1, '0, '0));
		send_setting(make_setting(32'd10_000_000, 8'd0, 12'd1, 8'd8, 8'd1, '0, '0));
		send_setting(make_setting(32'd10_000_000, 8'd0, 12'd1, 8'd255, 8'd1, '0, '0));
		send_setting(make_setting(32'd10_000_000, 8'd1, 12'd1, 8'd3, 8'd1, '0, '0));
		send_setting(make_setting(32'd10_000_000, 8'd1, 12'd1, 8'd7, 8'd1, '0, '0));
		send_setting(make_setting(32'd0, 8'd0, 12'd0, 8'd0, 8'd0, '0, '0));

		// random part, with one long receiver hold-off and a calm stretch
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			calm = (i >= 150) && (i < 210);
			if (i == 60)
				hold_request = 1'b1;
			send_setting(random_setting());
		end
		calm = 1'b0;
		setting_valid <= 1'b0;

		// drain, then let any stray word show up
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
